FILE: hw/rtl/hsl_to_rgb_converter_assert.svh
// Assertion macros used by the checker of the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HTR_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsl_to_rgb_converter: assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HTR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsl_to_rgb_converter: assertion failed");

`endif

FILE: hw/rtl/htr_pkg.sv
// Shared constants, types and arithmetic helpers of the HSL to RGB converter.
package htr_pkg;

	localparam int FRACTION_BITS     = 10;
	localparam int HUE_FRACTION_BITS = 4;

	localparam int HUE_W = 14;
	localparam int SL_W  = 11;
	localparam int CH_W  = 8;

	localparam int VAL_W  = FRACTION_BITS + 1;
	localparam int ONE    = 1 << FRACTION_BITS;
	localparam int SUM_W  = FRACTION_BITS + 2;

	// one 60-degree sector in hue units; HALF = 15 << SH
	localparam int HALF    = 60 << HUE_FRACTION_BITS;
	localparam int SH      = HUE_FRACTION_BITS + 2;
	localparam int HALF_W  = $clog2(HALF + 1);
	localparam int HUE_MAX = (1 << HUE_W) - 1;
	localparam int SEC_MAX = HUE_MAX / HALF;
	localparam int SEC_W   = $clog2(SEC_MAX + 1);
	localparam int PROD_W  = VAL_W + HALF_W;
	localparam int QN_W    = PROD_W - SH;

	// divide by 15 through a reciprocal: estimate is exact or one low
	localparam int     DQ_W  = 24;
	localparam longint RECIP = ((64'd1 << DQ_W) - 64'd1) / 15;

	localparam logic [SEC_W-1:0] SEC_R_TO_Y = SEC_W'(0);
	localparam logic [SEC_W-1:0] SEC_Y_TO_G = SEC_W'(1);
	localparam logic [SEC_W-1:0] SEC_G_TO_C = SEC_W'(2);
	localparam logic [SEC_W-1:0] SEC_C_TO_B = SEC_W'(3);
	localparam logic [SEC_W-1:0] SEC_B_TO_M = SEC_W'(4);

	typedef struct packed {
		logic               vld;
		logic [VAL_W-1:0]   chroma;
		logic [VAL_W-1:0]   light;
		logic [SEC_W-1:0]   sector;
		logic [HALF_W-1:0]  offset;
	} htr_front_t;

	typedef struct packed {
		logic               vld;
		logic [SUM_W-1:0]   sum_r;
		logic [SUM_W-1:0]   sum_g;
		logic [SUM_W-1:0]   sum_b;
	} htr_sum_t;

	function automatic logic [VAL_W-1:0] sat_one(input logic [SL_W-1:0] v);
		logic [31:0] e;
		e = 32'(v);
		return (e > 32'(ONE)) ? VAL_W'(ONE) : VAL_W'(e);
	endfunction

	function automatic logic [DQ_W-1:0] div15_est(input logic [DQ_W-1:0] n);
		logic [2*DQ_W-1:0] p;
		p = (2*DQ_W)'(n) * (2*DQ_W)'(RECIP);
		return p[2*DQ_W-1:DQ_W];
	endfunction

	function automatic logic [DQ_W-1:0] div15_fix(input logic [DQ_W-1:0] n,
		input logic [DQ_W-1:0] q0);
		logic [DQ_W-1:0] r;
		r = n - q0 * DQ_W'(15);
		return (r >= DQ_W'(15)) ? q0 + DQ_W'(1) : q0;
	endfunction

endpackage

FILE: hw/rtl/htr_front.sv
// Front stages: saturate inputs, form chroma, split hue into sector and offset.
module htr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_vld,
	input  logic [htr_pkg::HUE_W-1:0] hue,
	input  logic [htr_pkg::SL_W-1:0]  saturation,
	input  logic [htr_pkg::SL_W-1:0]  lightness,
	output htr_pkg::htr_front_t       front
);
	import htr_pkg::*;

	logic [VAL_W-1:0]   sat_c, light_c, onemd_c;
	logic [VAL_W:0]     two_l, one_x, l_dev;
	logic [HUE_W-1:0]   hn_c, hn2_c, base_c;
	logic [SEC_W-1:0]   q0h_c, sector_c;
	logic [2*VAL_W-1:0] cprod_c;

	logic               vld_s1;
	logic [VAL_W-1:0]   onemd_s1, sat_s1, light_s1;
	logic [HUE_W-1:0]   hue_s1;
	logic [SEC_W-1:0]   q0h_s1;
	logic               vld_s2;
	logic [VAL_W-1:0]   chroma_s2, light_s2;
	logic [SEC_W-1:0]   sector_s2;
	logic [HALF_W-1:0]  offset_s2;

	// stage 1: saturate, distance of 2L from 1.0, first sector estimate
	always_comb begin
		sat_c   = sat_one(saturation);
		light_c = sat_one(lightness);
		two_l   = {light_c, 1'b0};
		one_x   = (VAL_W+1)'(ONE);
		l_dev   = (two_l >= one_x) ? two_l - one_x : one_x - two_l;
		onemd_c = VAL_W'(one_x - l_dev);
		hn_c    = hue >> SH;
		q0h_c   = SEC_W'(div15_est(DQ_W'(hn_c)));
	end

	// stage 2: chroma product, correct the sector, offset inside it
	always_comb begin
		cprod_c  = (2*VAL_W)'(onemd_s1) * (2*VAL_W)'(sat_s1);
		hn2_c    = hue_s1 >> SH;
		sector_c = SEC_W'(div15_fix(DQ_W'(hn2_c), DQ_W'(q0h_s1)));
		base_c   = HUE_W'(32'(sector_c) * 32'(HALF));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			onemd_s1  <= onemd_c;
			sat_s1    <= sat_c;
			light_s1  <= light_c;
			hue_s1    <= hue;
			q0h_s1    <= q0h_c;
			chroma_s2 <= cprod_c[FRACTION_BITS +: VAL_W];
			light_s2  <= light_s1;
			sector_s2 <= sector_c;
			offset_s2 <= HALF_W'(hue_s1 - base_c);
		end
	end

	assign front = '{vld: vld_s2, chroma: chroma_s2, light: light_s2, sector: sector_s2,
		offset: offset_s2};

endmodule

FILE: hw/rtl/htr_xterm.sv
// Middle stages: intermediate term X by divide-by-60-degrees, channel sums.
module htr_xterm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  htr_pkg::htr_front_t front,
	output htr_pkg::htr_sum_t   sums
);
	import htr_pkg::*;

	logic [HALF_W-1:0] weight_c;
	logic [QN_W-1:0]   n_c;
	logic [VAL_W-1:0]  x_c, r_c, g_c, b_c;

	logic              vld_s3, vld_s4;
	logic [PROD_W-1:0] prod_s3;
	logic [VAL_W-1:0]  chroma_s3, light_s3, chroma_s4, light_s4;
	logic [SEC_W-1:0]  sector_s3, sector_s4;
	logic [QN_W-1:0]   n_s4, q0_s4;
	logic              vld_s5;
	logic [SUM_W-1:0]  sum_r_s5, sum_g_s5, sum_b_s5;

	// stage 3: weight rises in even sectors and falls in odd ones
	always_comb begin
		weight_c = front.sector[0] ? HALF_W'(HALF) - front.offset : front.offset;
	end

	// stage 4: drop the power-of-two part of the divisor, estimate the rest
	assign n_c = QN_W'(prod_s3 >> SH);

	// stage 5: finish X, place chroma and X on the channels
	always_comb begin
		x_c = VAL_W'(div15_fix(DQ_W'(n_s4), DQ_W'(q0_s4)));
		case (sector_s4)
			SEC_R_TO_Y: begin r_c = chroma_s4; g_c = x_c;       b_c = '0;        end
			SEC_Y_TO_G: begin r_c = x_c;       g_c = chroma_s4; b_c = '0;        end
			SEC_G_TO_C: begin r_c = '0;        g_c = chroma_s4; b_c = x_c;       end
			SEC_C_TO_B: begin r_c = '0;        g_c = x_c;       b_c = chroma_s4; end
			SEC_B_TO_M: begin r_c = x_c;       g_c = '0;        b_c = chroma_s4; end
			default:    begin r_c = chroma_s4; g_c = '0;        b_c = x_c;       end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= front.vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3   <= PROD_W'(front.chroma) * PROD_W'(weight_c);
			chroma_s3 <= front.chroma;
			light_s3  <= front.light;
			sector_s3 <= front.sector;
			n_s4      <= n_c;
			q0_s4     <= QN_W'(div15_est(DQ_W'(n_c)));
			chroma_s4 <= chroma_s3;
			light_s4  <= light_s3;
			sector_s4 <= sector_s3;
			// channel + offset at twice the scale: 2*part + 2L - C
			sum_r_s5  <= SUM_W'({r_c, 1'b0}) + SUM_W'({light_s4, 1'b0})
				- SUM_W'(chroma_s4);
			sum_g_s5  <= SUM_W'({g_c, 1'b0}) + SUM_W'({light_s4, 1'b0})
				- SUM_W'(chroma_s4);
			sum_b_s5  <= SUM_W'({b_c, 1'b0}) + SUM_W'({light_s4, 1'b0})
				- SUM_W'(chroma_s4);
		end
	end

	assign sums = '{vld: vld_s5, sum_r: sum_r_s5, sum_g: sum_g_s5, sum_b: sum_b_s5};

endmodule

FILE: hw/rtl/htr_scale.sv
// Output stage: scale each channel sum by 255, truncate and clamp.
module htr_scale (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  htr_pkg::htr_sum_t        sums,
	output logic                     out_vld,
	output logic [htr_pkg::CH_W-1:0] red,
	output logic [htr_pkg::CH_W-1:0] green,
	output logic [htr_pkg::CH_W-1:0] blue
);
	import htr_pkg::*;

	localparam int SP_W = SUM_W + CH_W;

	function automatic logic [CH_W-1:0] scale(input logic [SUM_W-1:0] s);
		logic [SP_W-1:0] p, v;
		p = SP_W'(s) * SP_W'(255);
		v = p >> (FRACTION_BITS + 1);
		return (v > SP_W'(255)) ? CH_W'(255) : v[CH_W-1:0];
	endfunction

	logic            vld_s6;
	logic [CH_W-1:0] red_s6, green_s6, blue_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= sums.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s6   <= scale(sums.sum_r);
			green_s6 <= scale(sums.sum_g);
			blue_s6  <= scale(sums.sum_b);
		end
	end

	assign out_vld = vld_s6;
	assign red     = red_s6;
	assign green   = green_s6;
	assign blue    = blue_s6;

endmodule

FILE: hw/rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter: six-stage pipeline, one pixel accepted per clock while the output is not stalled.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data registers keep
// whatever they hold, and the block takes input on the first cycle after release.
module hsl_to_rgb_converter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hsl_valid,
	output logic                      hsl_ready,
	input  logic [htr_pkg::HUE_W-1:0] hue,
	input  logic [htr_pkg::SL_W-1:0]  saturation,
	input  logic [htr_pkg::SL_W-1:0]  lightness,
	output logic                      rgb_valid,
	input  logic                      rgb_ready,
	output logic [htr_pkg::CH_W-1:0]  red,
	output logic [htr_pkg::CH_W-1:0]  green,
	output logic [htr_pkg::CH_W-1:0]  blue
);
	import htr_pkg::*;

	// Pipeline map:
	//   s1  saturate S and L, |2L - 1|, estimate hue / 60 degrees
	//   s2  chroma C = (1 - |2L - 1|) * S, exact sector, offset in the sector
	//   s3  C times the sector weight (distance from the sector edge)
	//   s4  divide by 60 degrees: shift out the power of two, estimate / 15
	//   s5  correct the quotient to get X, route C and X, form 2*part + 2L - C
	//   s6  multiply by 255, shift, clamp: the output register
	// Every stage moves together. Advance whenever the output register is
	// empty or its result is being taken; otherwise hold all stages.

	logic       adv;
	htr_front_t front;
	htr_sum_t   sums;

	assign adv       = !rgb_valid || rgb_ready;
	assign hsl_ready = adv;

	htr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_vld     (hsl_valid),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.front      (front)
	);

	htr_xterm u_xterm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.front  (front),
		.sums   (sums)
	);

	htr_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.sums    (sums),
		.out_vld (rgb_valid),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

endmodule

FILE: hw/rtl/htr_checker.sv
// Port-level checker for the HSL to RGB converter, bound to its top level.
`include "hsl_to_rgb_converter_assert.svh"

module htr_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     hsl_ready,
	input logic                     rgb_valid,
	input logic                     rgb_ready,
	input logic [htr_pkg::CH_W-1:0] red,
	input logic [htr_pkg::CH_W-1:0] green,
	input logic [htr_pkg::CH_W-1:0] blue
);
	logic [3*htr_pkg::CH_W-1:0] rgb_pixel;

	assign rgb_pixel = {red, green, blue};

	// a stalled result holds its pixel
	`HTR_ASSERT_NEXT(a_hold_stall, rgb_valid && !rgb_ready, rgb_valid && $stable(rgb_pixel))
	// a stalled result blocks every stage, so no new transfer is taken
	`HTR_ASSERT_NOW(a_full_blocks, rgb_valid && !rgb_ready, !hsl_ready)
	// with the output draining, the input side is open
	`HTR_ASSERT_NOW(a_drain_opens, rgb_ready, hsl_ready)
	// an empty output register never backpressures the input
	`HTR_ASSERT_NOW(a_empty_opens, !rgb_valid, hsl_ready)

endmodule

bind hsl_to_rgb_converter htr_checker u_htr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsl_ready (hsl_ready),
	.rgb_valid (rgb_valid),
	.rgb_ready (rgb_ready),
	.red       (red),
	.green     (green),
	.blue      (blue)
);
